### hdl/tcfd_pkg.sv
// Shared constants, types and helpers for the tiny CPU block.
package tcfd_pkg;

  localparam int unsigned MEM_WORDS = 4096;
  localparam int unsigned ADDR_W    = $clog2(MEM_WORDS);
  localparam int unsigned WORD_W    = 32;
  localparam int unsigned PC_W      = 17;
  localparam int unsigned REG_N     = 8;
  localparam int unsigned REG_AW    = $clog2(REG_N);

  localparam logic [PC_W-1:0] MEM_LIMIT = PC_W'(MEM_WORDS);

  typedef logic [WORD_W-1:0] word_t;

  typedef enum logic [1:0] {
    KIND_WRITE   = 2'd0,
    KIND_READ    = 2'd1,
    KIND_STEP    = 2'd2,
    KIND_RESTART = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    FAULT_NONE   = 2'd0,
    FAULT_FETCH  = 2'd1,
    FAULT_DATA   = 2'd2,
    FAULT_OPCODE = 2'd3
  } fault_t;

  localparam logic [3:0] OP_HALT  = 4'd0;
  localparam logic [3:0] OP_LOAD  = 4'd1;
  localparam logic [3:0] OP_ST    = 4'd2;
  localparam logic [3:0] OP_ADD   = 4'd3;
  localparam logic [3:0] OP_JUMP  = 4'd4;
  localparam logic [3:0] OP_MOVI  = 4'd5;
  localparam logic [3:0] OP_SUB   = 4'd6;

  typedef enum logic [2:0] {
    ALU_NONE,
    ALU_ADD,
    ALU_SUB,
    ALU_MOVI,
    ALU_LOAD,
    ALU_STORE
  } alu_t;

  typedef struct packed {
    logic              re;
    logic [ADDR_W-1:0] raddr;
    logic              we;
    logic [ADDR_W-1:0] waddr;
    word_t             wdata;
  } mem_req_t;

  typedef struct packed {
    logic              re;
    logic [REG_AW-1:0] raddr0;
    logic [REG_AW-1:0] raddr1;
    logic              we;
    logic [REG_AW-1:0] waddr;
    word_t             wdata;
    logic              clear;
  } rf_req_t;

  function automatic logic [REG_AW-1:0] reg_sel(input logic [3:0] field);
    return field[3] ? '0 : field[REG_AW-1:0];
  endfunction

endpackage

### hdl/tcfd_word_mem.sv
// Word memory: one read and one write port, registered read, zero sweep after reset.
module tcfd_word_mem (
  input  logic               clk,
  input  logic               rst,
  input  tcfd_pkg::mem_req_t req,
  output tcfd_pkg::word_t    rdata,
  output logic               busy
);

  tcfd_pkg::word_t mem [tcfd_pkg::MEM_WORDS];

  logic [tcfd_pkg::ADDR_W-1:0] clr_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b1;
      clr_addr <= '0;
    end else if (busy) begin
      clr_addr <= clr_addr + tcfd_pkg::ADDR_W'(1);
      if (clr_addr == tcfd_pkg::ADDR_W'(tcfd_pkg::MEM_WORDS - 1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (busy) begin
      mem[clr_addr] <= '0;
    end else if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
  end

  // forward a write to the same word in the same cycle
  always_ff @(posedge clk) begin
    if (req.re) begin
      if (req.we && (req.waddr == req.raddr)) begin
        rdata <= req.wdata;
      end else begin
        rdata <= mem[req.raddr];
      end
    end
  end

endmodule

### hdl/tcfd_reg_file.sv
// General register file: two registered read ports, one write port, clear on restart.
module tcfd_reg_file (
  input  logic              clk,
  input  logic              rst,
  input  tcfd_pkg::rf_req_t req,
  output tcfd_pkg::word_t   rdata0,
  output tcfd_pkg::word_t   rdata1
);

  tcfd_pkg::word_t             regs [tcfd_pkg::REG_N];
  logic [tcfd_pkg::REG_N-1:0]  valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (req.clear) begin
      valid <= '0;
    end else if (req.we) begin
      valid[req.waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (req.we) begin
      regs[req.waddr] <= req.wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (req.re) begin
      if (req.we && (req.waddr == req.raddr0)) begin
        rdata0 <= req.wdata;
      end else begin
        rdata0 <= valid[req.raddr0] ? regs[req.raddr0] : '0;
      end
      if (req.we && (req.waddr == req.raddr1)) begin
        rdata1 <= req.wdata;
      end else begin
        rdata1 <= valid[req.raddr1] ? regs[req.raddr1] : '0;
      end
    end
  end

endmodule

### hdl/tiny_cpu_fetch_decode_execute.sv
// Tiny 32-bit CPU top level: host word access, single-step execution, restart.
// After reset the block sweeps its 4096-word memory to zero, one word a cycle, and
// accepts no word until the sweep is done. The fetch or host read is issued at the
// edge that takes a word, which then runs through decode, execute and report
// stages plus an output register. A new word is not taken while the last one is
// in decode, since the read port of the word memory serves the fetch and then the
// data read of a LOAD, while its write port takes a host write or a STORE. The
// result register lets the next word in while a finished result still waits.
module tiny_cpu_fetch_decode_execute (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // address[15:0], write_data[47:16], reg_index[50:48], zero fill
  input  logic [55:0] s_axis_tdata,
  // kind[1:0]
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // read_data[31:0], reg_value[63:32], program_counter[80:64], is_halted[81],
  // zero_flag[82], sign_flag[83], carry_flag[84], fault[86:85],
  // executed_opcode[90:87], zero fill
  output logic [95:0] m_axis_tdata
);

  localparam int unsigned PC_W   = tcfd_pkg::PC_W;
  localparam int unsigned ADDR_W = tcfd_pkg::ADDR_W;

  tcfd_pkg::mem_req_t mem_req;
  tcfd_pkg::word_t    mem_rdata;
  logic               mem_busy;
  tcfd_pkg::rf_req_t  rf_req;
  tcfd_pkg::word_t    rf_rdata0;
  tcfd_pkg::word_t    rf_rdata1;

  // architectural state
  logic [PC_W-1:0] pc;
  logic            halted;
  logic            zf;
  logic            sf;
  logic            cf;

  // decode stage
  logic                         s1_valid;
  tcfd_pkg::kind_t              s1_kind;
  logic [15:0]                  s1_addr;
  tcfd_pkg::word_t              s1_wdata;
  logic [tcfd_pkg::REG_AW-1:0]  s1_sel;

  // execute stage
  logic                         s2_valid;
  tcfd_pkg::alu_t               s2_alu;
  logic [tcfd_pkg::REG_AW-1:0]  s2_sel;
  logic [tcfd_pkg::REG_AW-1:0]  s2_rd;
  logic [15:0]                  s2_imm;
  tcfd_pkg::fault_t             s2_fault;
  logic [3:0]                   s2_op;
  tcfd_pkg::word_t              s2_rdata;

  // report stage
  logic                         s3_valid;
  tcfd_pkg::word_t              s3_rdata;
  logic [PC_W-1:0]              s3_pc;
  logic                         s3_halted;
  logic                         s3_zf;
  logic                         s3_sf;
  logic                         s3_cf;
  tcfd_pkg::fault_t             s3_fault;
  logic [3:0]                   s3_op;

  logic                         out_valid;
  logic [95:0]                  out_data;

  logic en;
  logic s_fire;
  logic s1_adv;
  logic s2_adv;

  // decode signals
  logic [3:0]                   d1_op;
  logic [tcfd_pkg::REG_AW-1:0]  d1_rd;
  logic [tcfd_pkg::REG_AW-1:0]  d1_ra;
  logic [tcfd_pkg::REG_AW-1:0]  d1_rb;
  logic [15:0]                  d1_imm;
  logic                         d1_host_ok;
  logic                         d1_imm_ok;
  tcfd_pkg::alu_t               d1_alu;
  tcfd_pkg::fault_t             d1_fault;
  logic [3:0]                   d1_op_out;
  logic [PC_W-1:0]              d1_pc_next;
  logic                         d1_halted_next;
  tcfd_pkg::word_t              d1_rdata;

  // execute signals
  logic [tcfd_pkg::WORD_W:0]    e2_sum;
  logic [tcfd_pkg::WORD_W:0]    e2_diff;
  tcfd_pkg::word_t              e2_result;
  logic                         e2_rf_we;
  logic                         e2_zf;
  logic                         e2_sf;
  logic                         e2_cf;

  assign en            = !(s3_valid && out_valid && !m_axis_tready);
  assign s_axis_tready = en && !s1_valid && !mem_busy;
  assign s_fire        = s_axis_tvalid && s_axis_tready;
  assign s1_adv        = s1_valid && en;
  assign s2_adv        = s2_valid && en;

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_data;

  // decode
  always_comb begin
    d1_op          = mem_rdata[31:28];
    d1_rd          = tcfd_pkg::reg_sel(mem_rdata[27:24]);
    d1_ra          = tcfd_pkg::reg_sel(mem_rdata[23:20]);
    d1_rb          = tcfd_pkg::reg_sel(mem_rdata[19:16]);
    d1_imm         = mem_rdata[15:0];
    d1_host_ok     = {1'b0, s1_addr} < tcfd_pkg::MEM_LIMIT;
    d1_imm_ok      = {1'b0, d1_imm} < tcfd_pkg::MEM_LIMIT;
    d1_alu         = tcfd_pkg::ALU_NONE;
    d1_fault       = tcfd_pkg::FAULT_NONE;
    d1_op_out      = '0;
    d1_pc_next     = pc;
    d1_halted_next = halted;
    d1_rdata       = '0;
    unique case (s1_kind)
      tcfd_pkg::KIND_WRITE: begin
        if (!d1_host_ok) begin
          d1_fault = tcfd_pkg::FAULT_DATA;
        end
      end
      tcfd_pkg::KIND_READ: begin
        if (d1_host_ok) begin
          d1_rdata = mem_rdata;
        end else begin
          d1_fault = tcfd_pkg::FAULT_DATA;
        end
      end
      tcfd_pkg::KIND_STEP: begin
        if (!halted) begin
          if (pc >= tcfd_pkg::MEM_LIMIT) begin
            d1_halted_next = 1'b1;
            d1_fault       = tcfd_pkg::FAULT_FETCH;
          end else begin
            d1_pc_next = pc + PC_W'(1);
            d1_op_out  = d1_op;
            unique case (d1_op)
              tcfd_pkg::OP_HALT: begin
                d1_halted_next = 1'b1;
              end
              tcfd_pkg::OP_LOAD: begin
                if (d1_imm_ok) begin
                  d1_alu = tcfd_pkg::ALU_LOAD;
                end else begin
                  d1_halted_next = 1'b1;
                  d1_fault       = tcfd_pkg::FAULT_DATA;
                end
              end
              tcfd_pkg::OP_ST: begin
                if (d1_imm_ok) begin
                  d1_alu = tcfd_pkg::ALU_STORE;
                end else begin
                  d1_halted_next = 1'b1;
                  d1_fault       = tcfd_pkg::FAULT_DATA;
                end
              end
              tcfd_pkg::OP_ADD: begin
                d1_alu = tcfd_pkg::ALU_ADD;
              end
              tcfd_pkg::OP_JUMP: begin
                d1_pc_next = {1'b0, d1_imm};
              end
              tcfd_pkg::OP_MOVI: begin
                d1_alu = tcfd_pkg::ALU_MOVI;
              end
              tcfd_pkg::OP_SUB: begin
                d1_alu = tcfd_pkg::ALU_SUB;
              end
              default: begin
                d1_halted_next = 1'b1;
                d1_fault       = tcfd_pkg::FAULT_OPCODE;
              end
            endcase
          end
        end
      end
      tcfd_pkg::KIND_RESTART: begin
        d1_pc_next     = '0;
        d1_halted_next = 1'b0;
      end
    endcase
  end

  // execute
  always_comb begin
    e2_sum    = {1'b0, rf_rdata0} + {1'b0, rf_rdata1};
    e2_diff   = {1'b0, rf_rdata0} - {1'b0, rf_rdata1};
    e2_result = '0;
    e2_rf_we  = 1'b0;
    e2_zf     = zf;
    e2_sf     = sf;
    e2_cf     = cf;
    unique case (s2_alu)
      tcfd_pkg::ALU_ADD: begin
        e2_result = e2_sum[tcfd_pkg::WORD_W-1:0];
        e2_rf_we  = 1'b1;
        e2_cf     = e2_sum[tcfd_pkg::WORD_W];
        e2_zf     = (e2_result == '0);
        e2_sf     = e2_result[tcfd_pkg::WORD_W-1];
      end
      tcfd_pkg::ALU_SUB: begin
        e2_result = e2_diff[tcfd_pkg::WORD_W-1:0];
        e2_rf_we  = 1'b1;
        e2_cf     = e2_diff[tcfd_pkg::WORD_W];
        e2_zf     = (e2_result == '0);
        e2_sf     = e2_result[tcfd_pkg::WORD_W-1];
      end
      tcfd_pkg::ALU_MOVI: begin
        e2_result = {16'b0, s2_imm};
        e2_rf_we  = 1'b1;
        e2_zf     = (e2_result == '0);
        e2_sf     = e2_result[tcfd_pkg::WORD_W-1];
      end
      tcfd_pkg::ALU_LOAD: begin
        e2_result = mem_rdata;
        e2_rf_we  = 1'b1;
      end
      default: begin
        e2_result = '0;
      end
    endcase
  end

  // memory port steering
  always_comb begin
    mem_req = '0;
    if (s_fire) begin
      mem_req.re    = 1'b1;
      mem_req.raddr = (tcfd_pkg::kind_t'(s_axis_tuser) == tcfd_pkg::KIND_STEP) ?
                      pc[ADDR_W-1:0] : s_axis_tdata[ADDR_W-1:0];
    end else if (s1_adv && (d1_alu == tcfd_pkg::ALU_LOAD)) begin
      mem_req.re    = 1'b1;
      mem_req.raddr = d1_imm[ADDR_W-1:0];
    end
    if (s1_adv && (s1_kind == tcfd_pkg::KIND_WRITE) && d1_host_ok) begin
      mem_req.we    = 1'b1;
      mem_req.waddr = s1_addr[ADDR_W-1:0];
      mem_req.wdata = s1_wdata;
    end else if (s2_adv && (s2_alu == tcfd_pkg::ALU_STORE)) begin
      mem_req.we    = 1'b1;
      mem_req.waddr = s2_imm[ADDR_W-1:0];
      mem_req.wdata = rf_rdata0;
    end
  end

  // register file port steering
  always_comb begin
    rf_req        = '0;
    rf_req.re     = s1_adv || s2_adv;
    rf_req.raddr0 = s2_adv ? s2_sel : d1_ra;
    rf_req.raddr1 = d1_rb;
    rf_req.we     = s2_adv && e2_rf_we;
    rf_req.waddr  = s2_rd;
    rf_req.wdata  = e2_result;
    rf_req.clear  = s1_adv && (s1_kind == tcfd_pkg::KIND_RESTART);
  end

  tcfd_word_mem u_word_mem (
    .clk   (clk),
    .rst   (rst),
    .req   (mem_req),
    .rdata (mem_rdata),
    .busy  (mem_busy)
  );

  tcfd_reg_file u_reg_file (
    .clk    (clk),
    .rst    (rst),
    .req    (rf_req),
    .rdata0 (rf_rdata0),
    .rdata1 (rf_rdata1)
  );

  // architectural state
  always_ff @(posedge clk) begin
    if (rst) begin
      pc     <= '0;
      halted <= 1'b0;
      zf     <= 1'b0;
      sf     <= 1'b0;
      cf     <= 1'b0;
    end else begin
      if (s1_adv) begin
        pc     <= d1_pc_next;
        halted <= d1_halted_next;
        if (s1_kind == tcfd_pkg::KIND_RESTART) begin
          zf <= 1'b0;
          sf <= 1'b0;
          cf <= 1'b0;
        end
      end
      if (s2_adv) begin
        zf <= e2_zf;
        sf <= e2_sf;
        cf <= e2_cf;
      end
    end
  end

  // pipe control
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      s3_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (en) begin
        s1_valid <= s_fire;
        s2_valid <= s1_valid;
        s3_valid <= s2_valid;
      end
      if (s3_valid && en) begin
        out_valid <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // pipe payload
  always_ff @(posedge clk) begin
    if (s_fire) begin
      s1_kind  <= tcfd_pkg::kind_t'(s_axis_tuser);
      s1_addr  <= s_axis_tdata[15:0];
      s1_wdata <= s_axis_tdata[47:16];
      s1_sel   <= s_axis_tdata[50:48];
    end
    if (s1_adv) begin
      s2_alu   <= d1_alu;
      s2_sel   <= s1_sel;
      s2_rd    <= d1_rd;
      s2_imm   <= d1_imm;
      s2_fault <= d1_fault;
      s2_op    <= d1_op_out;
      s2_rdata <= d1_rdata;
    end
    if (s2_adv) begin
      s3_rdata  <= s2_rdata;
      s3_pc     <= pc;
      s3_halted <= halted;
      s3_zf     <= e2_zf;
      s3_sf     <= e2_sf;
      s3_cf     <= e2_cf;
      s3_fault  <= s2_fault;
      s3_op     <= s2_op;
    end
    if (s3_valid && en) begin
      out_data <= {5'b0, s3_op, s3_fault, s3_cf, s3_sf, s3_zf, s3_halted, s3_pc,
                   rf_rdata0, s3_rdata};
    end
  end

endmodule
